@@ hw/rtl/wqe_pkg.sv @@
// ----------------------------------------------------------------------------
// wqe_pkg
// shared types, constants and helpers of the weighted quantile engine
// ----------------------------------------------------------------------------
`default_nettype none

package wqe_pkg;

    localparam int VALUE_BITS      = 32;
    localparam int WEIGHT_BITS     = 15;
    localparam int PROB_BITS       = 17;
    localparam int FRAC_BITS       = 16;
    localparam int TYPE_BITS       = 4;
    localparam int STATUS_BITS     = 3;
    localparam int OFFSET_BITS     = 5;
    localparam int MAX_SAMPLES_DEF = 256;

    localparam logic [PROB_BITS-1:0] ONE_Q16 = PROB_BITS'(65536);

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_ZERO_TOT = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NEG_WGT  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 3'd4;

    localparam logic [TYPE_BITS-1:0] QT_TYPE1   = 4'd1;
    localparam logic [TYPE_BITS-1:0] QT_TYPE2   = 4'd2;
    localparam logic [TYPE_BITS-1:0] QT_TYPE3   = 4'd3;
    localparam logic [TYPE_BITS-1:0] QT_TYPE4   = 4'd4;
    localparam logic [TYPE_BITS-1:0] QT_TYPE5   = 4'd5;
    localparam logic [TYPE_BITS-1:0] QT_TYPE6   = 4'd6;
    localparam logic [TYPE_BITS-1:0] QT_TYPE7   = 4'd7;
    localparam logic [TYPE_BITS-1:0] QT_TYPE8   = 4'd8;
    localparam logic [TYPE_BITS-1:0] QT_TYPE9   = 4'd9;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [WEIGHT_BITS-1:0]       weight;
    } wqe_entry_t;

    typedef struct packed {
        logic insert;
        logic rotate;
    } wqe_cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_TOTAL,
        S_TOTAL,
        S_PREP,
        S_SCAN_FIND,
        S_RESOLVE,
        S_INTERP
    } wqe_state_t;

    typedef enum logic [1:0] {
        IP_IDLE,
        IP_MUL,
        IP_DIV
    } wqe_ip_state_t;

    // grid start offset in 1/24 units
    function automatic logic [OFFSET_BITS-1:0] start_24(input logic [TYPE_BITS-1:0] t);
        logic [OFFSET_BITS-1:0] r;
        case (t)
            QT_TYPE4: r = 5'd24;
            QT_TYPE5: r = 5'd12;
            QT_TYPE6: r = 5'd24;
            QT_TYPE8: r = 5'd16;
            QT_TYPE9: r = 5'd15;
            default:  r = 5'd0;
        endcase
        return r;
    endfunction

    // grid end offset in 1/24 units
    function automatic logic [OFFSET_BITS-1:0] end_24(input logic [TYPE_BITS-1:0] t);
        logic [OFFSET_BITS-1:0] r;
        case (t)
            QT_TYPE5: r = 5'd12;
            QT_TYPE6: r = 5'd24;
            QT_TYPE8: r = 5'd16;
            QT_TYPE9: r = 5'd15;
            default:  r = 5'd0;
        endcase
        return r;
    endfunction

    // floor of the halved sum
    function automatic logic signed [VALUE_BITS-1:0] avg_floor(
        input logic signed [VALUE_BITS-1:0] a,
        input logic signed [VALUE_BITS-1:0] b
    );
        logic signed [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        return s[VALUE_BITS:1];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/weighted_quantile_engine.sv @@
// ----------------------------------------------------------------------------
// weighted_quantile_engine
// value-sorted chain of sample cells with a sequential quantile controller
// ----------------------------------------------------------------------------
// push, clear and early-exit queries are taken in the idle state, busy stays low
// full query: a total scan and a find scan that rotate the whole chain, with the
//   total and prep checks between them, then, when interpolating, the shift-add
//   multiply, restoring divide and hand-back; result strobe in the cycle after
//   the last step, receiver never stalls
// reset: empty store, sticky flags clear, quantile_type 7
`default_nettype none

module weighted_quantile_engine
    import wqe_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   cmd,
    input  wire logic signed [VALUE_BITS-1:0] sample_value,
    input  wire logic signed [WEIGHT_BITS:0]  sample_weight,
    input  wire logic                         sample_missing,
    input  wire logic [PROB_BITS-1:0]         probability,
    input  wire logic                         cfg_we,
    input  wire logic [TYPE_BITS-1:0]         cfg_wdata,
    output logic                              done,
    output logic signed [VALUE_BITS-1:0]      quantile,
    output logic [STATUS_BITS-1:0]            status
);

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CUM_W = WEIGHT_BITS + IDX_W + OFFSET_BITS;
    localparam int PT_W  = CUM_W + PROB_BITS;
    localparam int CMP_W = CUM_W + FRAC_BITS + 2;
    localparam int MAG_W = VALUE_BITS + 1;

    wqe_state_t                 state_reg, state_next;
    logic [IDX_W-1:0]           k_reg, k_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       bad_reg, bad_next;
    logic                       ovf_reg, ovf_next;
    logic [TYPE_BITS-1:0]       type_reg, type_next;
    logic [TYPE_BITS-1:0]       qt_reg, qt_next;
    logic [PROB_BITS-1:0]       prob_reg, prob_next;
    logic [CUM_W-1:0]           acc_reg, acc_next;
    logic [WEIGHT_BITS-1:0]     pw_reg, pw_next;
    logic [WEIGHT_BITS-1:0]     wlast_reg, wlast_next;
    logic signed [VALUE_BITS-1:0] v0_reg, v0_next;
    logic signed [VALUE_BITS-1:0] vlast_reg, vlast_next;
    logic signed [VALUE_BITS-1:0] pv_reg, pv_next;
    logic [CUM_W-1:0]           total_reg, total_next;
    logic [PT_W-1:0]            pt_reg, pt_next;
    logic                       found_reg, found_next;
    logic [IDX_W-1:0]           fidx_reg, fidx_next;
    logic                       feq_reg, feq_next;
    logic signed [VALUE_BITS-1:0] fv_reg, fv_next;
    logic signed [VALUE_BITS-1:0] fpv_reg, fpv_next;
    logic signed [VALUE_BITS-1:0] fnext_reg, fnext_next;
    logic                       fnext_ok_reg, fnext_ok_next;
    logic [CUM_W-1:0]           fcum_reg, fcum_next;
    logic [CUM_W-1:0]           fpcum_reg, fpcum_next;
    logic                       neg_reg, neg_next;
    logic                       done_reg, done_next;
    logic signed [VALUE_BITS-1:0] quant_reg, quant_next;
    logic [STATUS_BITS-1:0]     status_reg, status_next;

    wqe_entry_t                 cells [MAX_SAMPLES];
    logic [MAX_SAMPLES-1:0]     keeps;
    wqe_entry_t                 ins_entry;
    wqe_cell_ctrl_t             cell_ctrl;

    logic                       accept;
    logic                       do_insert;
    logic                       kv;
    logic                       k_last;
    logic                       k_is_last_entry;
    logic [WEIGHT_BITS-1:0]     w_cur;
    logic signed [VALUE_BITS-1:0] v_cur;
    logic [CUM_W-1:0]           cum_cur;
    logic [CMP_W-1:0]           lhs;
    logic [CMP_W-1:0]           rhs;
    logic                       is_grid;

    logic                       ip_start;
    logic                       ip_done;
    logic [MAG_W-1:0]           ip_q;
    logic [PT_W-1:0]            ip_num;
    logic [MAG_W-1:0]           ip_mag;
    logic [CUM_W-1:0]           ip_den;
    logic signed [MAG_W-1:0]    vdiff;

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign quantile = quant_reg;
    assign status   = status_reg;

    assign accept    = start && !busy;
    assign do_insert = accept && (cmd == CMD_PUSH) && !sample_missing
                       && !sample_weight[WEIGHT_BITS]
                       && (count_reg < CNT_W'(MAX_SAMPLES));

    assign ins_entry.value  = sample_value;
    assign ins_entry.weight = sample_weight[WEIGHT_BITS-1:0];
    assign cell_ctrl.insert = do_insert;
    assign cell_ctrl.rotate = (state_reg == S_SCAN_TOTAL) || (state_reg == S_SCAN_FIND);

    for (genvar i = 0; i < MAX_SAMPLES; i++)
    begin : g_chain
        if (i == 0)
        begin : g_head
            wqe_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .occ         (CNT_W'(i) < count_reg),
                .ins_entry   (ins_entry),
                .left_entry  (ins_entry),
                .left_keep   (1'b1),
                .right_entry (cells[(i + 1) % MAX_SAMPLES]),
                .entry       (cells[i]),
                .keep        (keeps[i])
            );
        end
        else
        begin : g_body
            wqe_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .occ         (CNT_W'(i) < count_reg),
                .ins_entry   (ins_entry),
                .left_entry  (cells[i - 1]),
                .left_keep   (keeps[i - 1]),
                .right_entry (cells[(i + 1) % MAX_SAMPLES]),
                .entry       (cells[i]),
                .keep        (keeps[i])
            );
        end
    end

    assign vdiff  = {fv_reg[VALUE_BITS-1], fv_reg} - {fpv_reg[VALUE_BITS-1], fpv_reg};
    assign ip_mag = neg_reg ? MAG_W'(-vdiff) : MAG_W'(vdiff);
    assign ip_num = pt_reg - PT_W'({fpcum_reg, {FRAC_BITS{1'b0}}});
    assign ip_den = fcum_reg - fpcum_reg;

    wqe_interp #(
        .NUM_W (PT_W),
        .MAG_W (MAG_W),
        .DEN_W (CUM_W)
    ) u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ip_start),
        .num   (ip_num),
        .mag   (ip_mag),
        .den   (ip_den),
        .done  (ip_done),
        .q     (ip_q)
    );

    assign w_cur           = cells[0].weight;
    assign v_cur           = cells[0].value;
    assign kv              = {1'b0, k_reg} < (CNT_W + 1)'(count_reg);
    assign k_last          = (k_reg == IDX_W'(MAX_SAMPLES - 1));
    assign k_is_last_entry = ((CNT_W + 1)'(k_reg) + 1'b1) == (CNT_W + 1)'(count_reg);
    assign is_grid         = (qt_reg >= QT_TYPE4);

    always_comb
    begin
        if (!is_grid)
        begin
            cum_cur = acc_reg + CUM_W'(w_cur);
        end
        else if (k_reg == '0)
        begin
            cum_cur = CUM_W'(w_cur) * CUM_W'(start_24(qt_reg));
        end
        else
        begin
            cum_cur = acc_reg + (CUM_W'(pw_reg) + CUM_W'(w_cur)) * CUM_W'(4'd12);
        end
        if (qt_reg == QT_TYPE3)
        begin
            lhs = CMP_W'({(CUM_W + 1)'(acc_reg) + (CUM_W + 1)'(cum_cur),
                          {FRAC_BITS{1'b0}}});
            rhs = CMP_W'({pt_reg, 1'b0});
        end
        else
        begin
            lhs = CMP_W'({cum_cur, {FRAC_BITS{1'b0}}});
            rhs = CMP_W'(pt_reg);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        count_next    = count_reg;
        bad_next      = bad_reg;
        ovf_next      = ovf_reg;
        type_next     = type_reg;
        qt_next       = qt_reg;
        prob_next     = prob_reg;
        acc_next      = acc_reg;
        pw_next       = pw_reg;
        wlast_next    = wlast_reg;
        v0_next       = v0_reg;
        vlast_next    = vlast_reg;
        pv_next       = pv_reg;
        total_next    = total_reg;
        pt_next       = pt_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        feq_next      = feq_reg;
        fv_next       = fv_reg;
        fpv_next      = fpv_reg;
        fnext_next    = fnext_reg;
        fnext_ok_next = fnext_ok_reg;
        fcum_next     = fcum_reg;
        fpcum_next    = fpcum_reg;
        neg_next      = neg_reg;
        done_next     = 1'b0;
        quant_next    = quant_reg;
        status_next   = status_reg;
        ip_start      = 1'b0;

        if (cfg_we)
        begin
            type_next = cfg_wdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_PUSH:
                        begin
                            if (!sample_missing)
                            begin
                                if (sample_weight[WEIGHT_BITS])
                                begin
                                    bad_next = 1'b1;
                                end
                                else if (count_reg >= CNT_W'(MAX_SAMPLES))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            bad_next   = 1'b0;
                            ovf_next   = 1'b0;
                        end
                        CMD_QUERY:
                        begin
                            if (bad_reg || ovf_reg || (count_reg <= CNT_W'(1)))
                            begin
                                done_next   = 1'b1;
                                quant_next  = '0;
                                if (bad_reg)
                                begin
                                    status_next = ST_NEG_WGT;
                                end
                                else if (ovf_reg)
                                begin
                                    status_next = ST_OVERFLOW;
                                end
                                else if (count_reg == '0)
                                begin
                                    status_next = ST_EMPTY;
                                end
                                else
                                begin
                                    status_next = ST_OK;
                                    quant_next  = cells[0].value;
                                end
                            end
                            else
                            begin
                                qt_next    = ((type_reg < QT_TYPE1) || (type_reg > QT_TYPE9))
                                             ? QT_TYPE7 : type_reg;
                                prob_next  = probability;
                                acc_next   = '0;
                                pw_next    = '0;
                                k_next     = '0;
                                state_next = S_SCAN_TOTAL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN_TOTAL:
            begin
                if (kv)
                begin
                    acc_next = cum_cur;
                    pw_next  = w_cur;
                    if (k_reg == '0)
                    begin
                        v0_next = v_cur;
                    end
                    if (k_is_last_entry)
                    begin
                        vlast_next = v_cur;
                        wlast_next = w_cur;
                    end
                end
                k_next = k_reg + 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = S_TOTAL;
                end
            end
            S_TOTAL:
            begin
                total_next = acc_reg + CUM_W'(wlast_reg) * CUM_W'(end_24(qt_reg));
                state_next = S_PREP;
            end
            S_PREP:
            begin
                if ((total_reg == '0) || (prob_reg == '0) || (prob_reg >= ONE_Q16))
                begin
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                    status_next = ST_OK;
                    if (total_reg == '0)
                    begin
                        status_next = ST_ZERO_TOT;
                        quant_next  = '0;
                    end
                    else if (prob_reg == '0)
                    begin
                        quant_next = v0_reg;
                    end
                    else
                    begin
                        quant_next = vlast_reg;
                    end
                end
                else
                begin
                    pt_next       = PT_W'(prob_reg) * PT_W'(total_reg);
                    acc_next      = '0;
                    pw_next       = '0;
                    pv_next       = '0;
                    found_next    = 1'b0;
                    fnext_ok_next = 1'b0;
                    k_next        = '0;
                    state_next    = S_SCAN_FIND;
                end
            end
            S_SCAN_FIND:
            begin
                if (kv && !found_reg)
                begin
                    acc_next = cum_cur;
                    pw_next  = w_cur;
                    pv_next  = v_cur;
                    if (lhs >= rhs)
                    begin
                        found_next = 1'b1;
                        fidx_next  = k_reg;
                        feq_next   = (lhs == rhs);
                        fv_next    = v_cur;
                        fpv_next   = pv_reg;
                        fcum_next  = cum_cur;
                        fpcum_next = acc_reg;
                    end
                end
                if (found_reg && kv && ((IDX_W + 1)'(k_reg) == (IDX_W + 1)'(fidx_reg) + 1'b1))
                begin
                    fnext_next    = v_cur;
                    fnext_ok_next = 1'b1;
                end
                k_next = k_reg + 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                status_next = ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
                if (!found_reg)
                begin
                    quant_next = vlast_reg;
                end
                else if (qt_reg == QT_TYPE3)
                begin
                    if (feq_reg)
                    begin
                        quant_next = fidx_reg[0] ? fpv_reg : fv_reg;
                    end
                    else
                    begin
                        quant_next = (fidx_reg == '0) ? fv_reg : fpv_reg;
                    end
                end
                else if (!is_grid)
                begin
                    if ((qt_reg == QT_TYPE2) && feq_reg && fnext_ok_reg)
                    begin
                        quant_next = avg_floor(fv_reg, fnext_reg);
                    end
                    else
                    begin
                        quant_next = fv_reg;
                    end
                end
                else if (fidx_reg == '0)
                begin
                    quant_next = fv_reg;
                end
                else if (fcum_reg == fpcum_reg)
                begin
                    quant_next = avg_floor(fpv_reg, fv_reg);
                end
                else
                begin
                    done_next  = 1'b0;
                    neg_next   = vdiff[MAG_W-1];
                    ip_start   = 1'b1;
                    state_next = S_INTERP;
                end
            end
            S_INTERP:
            begin
                if (ip_done)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    quant_next  = neg_reg ? VALUE_BITS'(fpv_reg - ip_q[VALUE_BITS-1:0])
                                          : VALUE_BITS'(fpv_reg + ip_q[VALUE_BITS-1:0]);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            count_reg    <= '0;
            bad_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            type_reg     <= QT_TYPE7;
            qt_reg       <= QT_TYPE7;
            found_reg    <= 1'b0;
            fnext_ok_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            count_reg    <= count_next;
            bad_reg      <= bad_next;
            ovf_reg      <= ovf_next;
            type_reg     <= type_next;
            qt_reg       <= qt_next;
            found_reg    <= found_next;
            fnext_ok_reg <= fnext_ok_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prob_reg   <= prob_next;
        acc_reg    <= acc_next;
        pw_reg     <= pw_next;
        wlast_reg  <= wlast_next;
        v0_reg     <= v0_next;
        vlast_reg  <= vlast_next;
        pv_reg     <= pv_next;
        total_reg  <= total_next;
        pt_reg     <= pt_next;
        fidx_reg   <= fidx_next;
        feq_reg    <= feq_next;
        fv_reg     <= fv_next;
        fpv_reg    <= fpv_next;
        fnext_reg  <= fnext_next;
        fcum_reg   <= fcum_next;
        fpcum_reg  <= fpcum_next;
        neg_reg    <= neg_next;
        quant_reg  <= quant_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/wqe_cell.sv @@
// ----------------------------------------------------------------------------
// wqe_cell
// one slot of the sorted sample chain: holds, inserts, shifts or rotates
// ----------------------------------------------------------------------------
`default_nettype none

module wqe_cell
    import wqe_pkg::*;
(
    input  wire logic           clk,
    input  wire wqe_cell_ctrl_t ctrl,
    input  wire logic           occ,
    input  wire wqe_entry_t     ins_entry,
    input  wire wqe_entry_t     left_entry,
    input  wire logic           left_keep,
    input  wire wqe_entry_t     right_entry,
    output wqe_entry_t          entry,
    output logic                keep
);

    wqe_entry_t entry_reg;
    wqe_entry_t entry_next;

    assign entry = entry_reg;
    assign keep  = occ && ($signed(entry_reg.value) <= $signed(ins_entry.value));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? ins_entry : left_entry;
            end
        end
        else if (ctrl.rotate)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/wqe_interp.sv @@
// ----------------------------------------------------------------------------
// wqe_interp
// shift-add multiply then restoring divide: q = floor((num * mag >> 16) / den)
// ----------------------------------------------------------------------------
`default_nettype none

module wqe_interp
    import wqe_pkg::*;
#(
    parameter int NUM_W = 45,
    parameter int MAG_W = 33,
    parameter int DEN_W = 28
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [MAG_W-1:0] mag,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [MAG_W-1:0]      q
);

    localparam int PROD_W = NUM_W + MAG_W;
    localparam int DVD_W  = PROD_W - FRAC_BITS;
    localparam int CW     = $clog2(DVD_W + 1);

    wqe_ip_state_t      state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [PROD_W-1:0]  num_sh_reg, num_sh_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic               done_reg, done_next;
    logic [PROD_W-1:0]  sum;
    logic [DEN_W:0]     rem_sh;
    logic               qbit;

    assign done = done_reg;
    assign q    = dvd_reg[MAG_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        num_sh_next = num_sh_reg;
        mag_next    = mag_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        done_next   = 1'b0;
        sum         = prod_reg + (mag_reg[0] ? num_sh_reg : '0);
        rem_sh      = {rem_reg, dvd_reg[DVD_W-1]};
        qbit        = (rem_sh >= {1'b0, den});
        case (state_reg)
            IP_IDLE:
            begin
                if (start)
                begin
                    num_sh_next = PROD_W'(num);
                    mag_next    = mag;
                    prod_next   = '0;
                    cnt_next    = CW'(MAG_W - 1);
                    state_next  = IP_MUL;
                end
            end
            IP_MUL:
            begin
                prod_next   = sum;
                num_sh_next = num_sh_reg << 1;
                mag_next    = mag_reg >> 1;
                if (cnt_reg == '0)
                begin
                    dvd_next   = sum[PROD_W-1:FRAC_BITS];
                    rem_next   = '0;
                    cnt_next   = CW'(DVD_W - 1);
                    state_next = IP_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            IP_DIV:
            begin
                rem_next = qbit ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], qbit};
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = IP_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = IP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IP_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        num_sh_reg <= num_sh_next;
        mag_reg    <= mag_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
    end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the weighted quantile engine: a queue-fed driver
// sends push, query, clear and ignored beats with random gaps, an in-bench
// model of the sorted store predicts every query answer, and a monitor
// compares each done strobe against the oldest predicted answer
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import wqe_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int STORE_DEPTH = 256;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT = 10000;
    localparam int RANDOM_ITEMS = 1700;

    typedef enum logic [1:0] {
        K_BEAT,
        K_CFG,
        K_DRAIN
    } item_kind_t;

    typedef struct {
        item_kind_t                   kind;
        logic [1:0]                   op;
        logic signed [VALUE_BITS-1:0] value;
        logic signed [WEIGHT_BITS:0]  weight;
        logic                         missing;
        logic [PROB_BITS-1:0]         prob;
        logic [TYPE_BITS-1:0]         qtype;
        int                           gap;
    } item_t;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic [STATUS_BITS-1:0]       st;
    } answer_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   cmd;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic signed [WEIGHT_BITS:0]  sample_weight;
    logic                         sample_missing;
    logic [PROB_BITS-1:0]         probability;
    logic                         cfg_we;
    logic [TYPE_BITS-1:0]         cfg_wdata;
    logic                         done;
    logic signed [VALUE_BITS-1:0] quantile;
    logic [STATUS_BITS-1:0]       status;

    weighted_quantile_engine uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .sample_value   (sample_value),
        .sample_weight  (sample_weight),
        .sample_missing (sample_missing),
        .probability    (probability),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .quantile       (quantile),
        .status         (status)
    );

    // model of the sorted store
    longint          store_val [STORE_DEPTH];
    longint unsigned store_wgt [STORE_DEPTH];
    int              store_cnt;
    bit              neg_flag;
    bit              ovf_flag;
    logic [TYPE_BITS-1:0] cur_type;
    longint unsigned grid_lead [10] = '{0, 0, 0, 0, 24, 12, 24, 0, 16, 15};
    longint unsigned grid_tail [10] = '{0, 0, 0, 0, 0, 12, 24, 0, 16, 15};

    item_t   pending [$];
    answer_t expected_answers [$];

    int fail_count;
    int pushes_sent;
    int queries_checked;
    int cfg_writes;
    int overflow_hits;
    int stall_cycles;

    item_t cur;
    bit    have_item;
    int    gap_left;
    int    settle;
    logic  nxt_start;
    logic  nxt_we;

    function automatic answer_t compute_quantile(logic [PROB_BITS-1:0] p);
        answer_t         a;
        int              n;
        int              i;
        int              t;
        longint unsigned cum [STORE_DEPTH];
        longint unsigned total;
        longint unsigned acc;
        longint unsigned pt;
        longint unsigned prev;
        longint unsigned m;
        longint unsigned num;
        longint unsigned den;
        longint unsigned mag;
        logic [127:0]    prod;
        longint          pv;
        longint          cv;
        longint          r;
        a.value = '0;
        n = store_cnt;
        t = cur_type;
        r = 0;
        if (neg_flag) begin a.st = ST_NEG_WGT; return a; end
        if (ovf_flag) begin a.st = ST_OVERFLOW; return a; end
        if (n == 0) begin a.st = ST_EMPTY; return a; end
        a.st = ST_OK;
        if (n == 1) begin a.value = store_val[0][VALUE_BITS-1:0]; return a; end
        if (t < 1 || t > 9) t = 7;
        if (t <= 3) begin
            acc = 0;
            for (i = 0; i < n; i++) begin acc += store_wgt[i]; cum[i] = acc; end
            total = acc;
        end else begin
            acc = store_wgt[0] * grid_lead[t];
            cum[0] = acc;
            for (i = 1; i < n; i++) begin
                acc += 12 * (store_wgt[i-1] + store_wgt[i]);
                cum[i] = acc;
            end
            total = acc + store_wgt[n-1] * grid_tail[t];
        end
        if (total == 0) begin a.st = ST_ZERO_TOT; return a; end
        if (p == 0) begin a.value = store_val[0][VALUE_BITS-1:0]; return a; end
        if (p >= ONE_Q16) begin a.value = store_val[n-1][VALUE_BITS-1:0]; return a; end
        pt = longint'(p) * total;
        if (t == 3) begin
            prev = 0;
            m = 0;
            for (i = 0; i < n; i++) begin
                m = prev + cum[i];
                if (m * 65536 >= 2 * pt) break;
                prev = cum[i];
            end
            if (i >= n) r = store_val[n-1];
            else if (m * 65536 == 2 * pt) r = (i % 2 == 0) ? store_val[i] : store_val[i-1];
            else if (i == 0) r = store_val[0];
            else r = store_val[i-1];
            a.value = r[VALUE_BITS-1:0];
            return a;
        end
        for (i = 0; i < n; i++)
            if (cum[i] * 65536 >= pt) break;
        if (t <= 2) begin
            if (i >= n) i = n - 1;
            if (t == 2 && cum[i] * 65536 == pt && i + 1 < n)
                r = (store_val[i] + store_val[i+1]) >>> 1;
            else
                r = store_val[i];
        end else if (i >= n) begin
            r = store_val[n-1];
        end else if (i == 0) begin
            r = store_val[0];
        end else begin
            pv = store_val[i-1];
            cv = store_val[i];
            if (cum[i] == cum[i-1]) begin
                r = (pv + cv) >>> 1;
            end else begin
                num = pt - cum[i-1] * 65536;
                den = (cum[i] - cum[i-1]) * 65536;
                mag = (cv >= pv) ? longint'(cv - pv) : longint'(pv - cv);
                prod = 128'(num) * 128'(mag);
                prod = prod / 128'(den);
                r = (cv >= pv) ? pv + longint'(prod[63:0]) : pv - longint'(prod[63:0]);
            end
        end
        a.value = r[VALUE_BITS-1:0];
        return a;
    endfunction

    function automatic void apply_beat(item_t it);
        int pos;
        int k;
        case (it.op)
            CMD_PUSH: begin
                pushes_sent++;
                if (!it.missing) begin
                    if (it.weight < 0) begin
                        neg_flag = 1'b1;
                    end else if (store_cnt >= STORE_DEPTH) begin
                        ovf_flag = 1'b1;
                        overflow_hits++;
                    end else begin
                        pos = 0;
                        while (pos < store_cnt && store_val[pos] <= longint'(it.value)) pos++;
                        for (k = store_cnt; k > pos; k--) begin
                            store_val[k] = store_val[k-1];
                            store_wgt[k] = store_wgt[k-1];
                        end
                        store_val[pos] = longint'(it.value);
                        store_wgt[pos] = longint'(it.weight);
                        store_cnt++;
                    end
                end
            end
            CMD_CLEAR: begin
                store_cnt = 0;
                neg_flag = 1'b0;
                ovf_flag = 1'b0;
            end
            CMD_QUERY: expected_answers.insert(expected_answers.size(),
                                               compute_quantile(it.prob));
            default: ;
        endcase
    endfunction

    function automatic void add_beat(logic [1:0] op, logic signed [VALUE_BITS-1:0] v,
                                     logic signed [WEIGHT_BITS:0] w, logic miss,
                                     logic [PROB_BITS-1:0] p, int gap);
        item_t it;
        it.kind = K_BEAT;
        it.op = op;
        it.value = v;
        it.weight = w;
        it.missing = miss;
        it.prob = p;
        it.qtype = '0;
        it.gap = gap;
        pending.insert(pending.size(), it);
    endfunction

    function automatic void add_control(item_kind_t kind, logic [TYPE_BITS-1:0] t);
        item_t it;
        it.kind = kind;
        it.op = CMD_NONE;
        it.value = '0;
        it.weight = '0;
        it.missing = 1'b0;
        it.prob = '0;
        it.qtype = t;
        it.gap = 0;
        pending.insert(pending.size(), it);
    endfunction

    function automatic logic [PROB_BITS-1:0] pick_prob();
        int sel;
        int d;
        sel = $urandom_range(0, 9);
        d = $urandom_range(2, 12);
        case (sel)
            0: return '0;
            1: return ONE_Q16;
            2: return PROB_BITS'($urandom_range(65537, 131071));
            3, 4: return PROB_BITS'($urandom_range(1, d - 1) * 65536 / d);
            default: return PROB_BITS'($urandom_range(1, 65535));
        endcase
    endfunction

    always #1 clk = ~clk;

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            nxt_start = start;
            nxt_we = 1'b0;
            if (start && !busy) begin
                apply_beat(cur);
                have_item = 1'b0;
                nxt_start = 1'b0;
            end
            if (!have_item && pending.size() > 0) begin
                cur = pending.pop_front();
                have_item = 1'b1;
                gap_left = cur.gap;
                settle = 0;
            end
            if (have_item && !nxt_start) begin
                if (cur.kind == K_BEAT) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        cmd <= cur.op;
                        sample_value <= cur.value;
                        sample_weight <= cur.weight;
                        sample_missing <= cur.missing;
                        probability <= cur.prob;
                        nxt_start = 1'b1;
                    end
                end else begin
                    if (expected_answers.size() == 0 && !busy && !done) settle++;
                    else settle = 0;
                    if (settle >= SETTLE_CYCLES) begin
                        if (cur.kind == K_CFG) begin
                            nxt_we = 1'b1;
                            cfg_wdata <= cur.qtype;
                            cur_type = cur.qtype;
                            cfg_writes++;
                        end
                        have_item = 1'b0;
                    end
                end
            end
            start <= nxt_start;
            cfg_we <= nxt_we;
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_answers.size() == 0) begin
                $error("unexpected result beat: quantile %0d status %0d", quantile, status);
                fail_count++;
            end else begin
                if (quantile !== expected_answers[0].value) begin
                    $error("quantile: expected %0d, got %0d", expected_answers[0].value, quantile);
                    fail_count++;
                end
                if (status !== expected_answers[0].st) begin
                    $error("status: expected %0d, got %0d", expected_answers[0].st, status);
                    fail_count++;
                end
                void'(expected_answers.pop_front());
                queries_checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done || cfg_we) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout with %0d answers outstanding", expected_answers.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int total_items;
        int n;
        int k;
        int q;
        int vmode;
        int wmode;
        int gmode;
        int session;
        logic signed [VALUE_BITS-1:0] v;
        logic signed [WEIGHT_BITS:0]  w;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_NONE;
        sample_value = '0;
        sample_weight = '0;
        sample_missing = 1'b0;
        probability = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        store_cnt = 0;
        neg_flag = 1'b0;
        ovf_flag = 1'b0;
        cur_type = QT_TYPE7;
        have_item = 1'b0;
        gap_left = 0;
        settle = 0;
        fail_count = 0;
        pushes_sent = 0;
        queries_checked = 0;
        cfg_writes = 0;
        overflow_hits = 0;
        stall_cycles = 0;

        // directed beats
        add_beat(CMD_QUERY, 0, 0, 1'b0, 17'd32768, 0);
        add_beat(CMD_PUSH, 32'sd77, 16'sd0, 1'b0, 0, 0);
        add_beat(CMD_QUERY, 0, 0, 1'b0, 17'd100, 1);
        add_beat(CMD_PUSH, -32'sd5, 16'sd0, 1'b0, 0, 0);
        add_beat(CMD_QUERY, 0, 0, 1'b0, 17'd40000, 0);
        add_beat(CMD_PUSH, 32'h8000_0000, 16'sd32767, 1'b0, 0, 2);
        add_beat(CMD_PUSH, 32'h7fff_ffff, 16'sd32767, 1'b0, 0, 0);
        add_beat(CMD_PUSH, 32'h7fff_ffff, -16'sd1, 1'b1, 0, 0);
        add_beat(CMD_QUERY, 0, 0, 1'b0, 17'd0, 0);
        add_beat(CMD_QUERY, 0, 0, 1'b0, 17'd65536, 0);
        add_beat(CMD_QUERY, 0, 0, 1'b0, 17'h1ffff, 3);
        add_beat(CMD_QUERY, 0, 0, 1'b0, 17'd32768, 0);
        add_beat(CMD_NONE, 32'h7fff_ffff, 16'sd1, 1'b1, 17'h1ffff, 0);
        add_control(K_DRAIN, 0);
        add_control(K_CFG, QT_TYPE2);
        add_beat(CMD_QUERY, 0, 0, 1'b0, 17'd32768, 0);
        add_beat(CMD_PUSH, 32'sd9, -16'sd32768, 1'b0, 0, 0);
        add_beat(CMD_QUERY, 0, 0, 1'b0, 17'd1, 0);
        add_beat(CMD_CLEAR, 0, 0, 1'b0, 0, 0);
        add_beat(CMD_QUERY, 0, 0, 1'b0, 17'd1, 0);
        total_items = 20;

        // random sessions: clear, fill, query
        session = 0;
        while (total_items < RANDOM_ITEMS) begin
            if (session % 4 == 0) begin
                case ($urandom_range(0, 5))
                    0: add_control(K_CFG, 4'd0);
                    1: add_control(K_CFG, 4'd15);
                    2: add_control(K_CFG, QT_TYPE1);
                    3: add_control(K_CFG, QT_TYPE9);
                    default: add_control(K_CFG, TYPE_BITS'($urandom_range(1, 9)));
                endcase
            end
            if (session % 10 == 5) add_control(K_DRAIN, 0);
            gmode = $urandom_range(0, 3);
            vmode = $urandom_range(0, 2);
            wmode = $urandom_range(0, 3);
            add_beat(CMD_CLEAR, 0, 0, 1'b0, 0, (gmode == 0) ? 0 : $urandom_range(0, 5));
            n = ($urandom_range(0, 24) == 0) ? STORE_DEPTH + $urandom_range(1, 3)
                                             : $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
                case (vmode)
                    0: v = $signed($urandom_range(0, 8)) - 4;
                    1: v = $urandom;
                    default: v = $signed($urandom_range(0, 2000)) - 1000;
                endcase
                case (wmode)
                    0: w = $urandom_range(0, 3);
                    1: w = $urandom_range(0, 32767);
                    2: w = $urandom_range(0, 1) ? 16'sd0 : 16'sd32767;
                    default: w = $urandom_range(1, 20);
                endcase
                if ($urandom_range(0, 60) == 0) w = -$signed({1'b0, 15'($urandom)}) - 1;
                add_beat(CMD_PUSH, v, w, $urandom_range(0, 12) == 0 ? 1'b1 : 1'b0,
                         PROB_BITS'($urandom), (gmode == 0) ? 0 : $urandom_range(0, 5));
                if ($urandom_range(0, 20) == 0)
                    add_beat(CMD_NONE, $urandom, $urandom, 1'($urandom),
                             PROB_BITS'($urandom), 0);
            end
            q = $urandom_range(2, 5);
            for (k = 0; k < q; k++)
                add_beat(CMD_QUERY, $urandom, $urandom, 1'($urandom), pick_prob(),
                         (gmode == 0) ? 0 : $urandom_range(0, 5));
            total_items += n + q + 1;
            session++;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending.size() == 0 && !have_item && expected_answers.size() == 0);
        repeat (40) @(posedge clk);
        $display("covered %0d sessions: %0d pushes, %0d query answers checked,",
                 session, pushes_sent, queries_checked);
        $display("%0d type register writes, %0d store overflow drops", cfg_writes,
                 overflow_hits);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/wqe_pkg.sv
hw/rtl/wqe_cell.sv
hw/rtl/wqe_interp.sv
hw/rtl/weighted_quantile_engine.sv
verif/tb.sv
